// ===== src/fcaa_pkg.sv =====
// Shared constants, register indexes and types of the four-channel converter averager.
// Used by fcaa_acc, fcaa_div and four_channel_adc_averager; depends on nothing.
package fcaa_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int MAX_ROUNDS = 8;
  localparam int ROUND_W    = $clog2(MAX_ROUNDS + 1);
  localparam int SUM_W      = SAMPLE_W + $clog2(MAX_ROUNDS);
  localparam int BIT_CNT_W  = $clog2(SUM_W);
  localparam int NUM_CH     = 4;
  localparam int CH_W       = 2;
  localparam int COUNT_W    = 8;
  localparam int TEMP_W     = 14;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE = SAMPLE_W'((1 << SAMPLE_W) - 1);
  localparam logic [TEMP_W-1:0]   TEMP_BASE  = TEMP_W'(300);

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_OFFSET  = CFG_IDX_W'(1);

  localparam logic KIND_VOLTAGE = 1'b0;
  localparam logic KIND_TEMP    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV_GO,
    ST_DIV_RUN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic            clear;
    logic            shift;
    logic            first;
    logic [CH_W-1:0] idx;
  } acc_ctrl_t;

endpackage

// ===== src/four_channel_adc_averager.sv =====
// Top level of the four-channel converter averager: control sequencer, registers, result stage.
// Depends on fcaa_pkg, fcaa_acc and fcaa_div.
// A voltage item is added bit-serially into its channel sum by a 13-bit serial add before the next
// item is accepted. The voltage item that completes the configured number of rounds adds a divide
// pass over the four channels through one shared restoring divider before the result and the next
// acceptance. A temperature item goes straight to the result stage. Results wait in an output
// register, so an item is taken while an earlier result is still stalled, as long as no new result
// must be loaded.
module four_channel_adc_averager (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                mode_i,
  input  logic [fcaa_pkg::SAMPLE_W-1:0]       sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                kind_o,
  output logic [fcaa_pkg::SAMPLE_W-1:0]       x1_level_o,
  output logic [fcaa_pkg::SAMPLE_W-1:0]       x2_level_o,
  output logic [fcaa_pkg::SAMPLE_W-1:0]       y1_level_o,
  output logic [fcaa_pkg::SAMPLE_W-1:0]       y2_level_o,
  output logic signed [fcaa_pkg::TEMP_W-1:0]  temp_value_o,
  input  logic                                cfg_we_i,
  input  logic [fcaa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fcaa_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  fcaa_pkg::state_e state_q, state_d;

  logic [fcaa_pkg::COUNT_W-1:0]   sample_count_q;
  logic [fcaa_pkg::SAMPLE_W-1:0]  temp_offset_q;
  logic [fcaa_pkg::CH_W-1:0]      channel_pos_q, channel_pos_d;
  logic [fcaa_pkg::ROUND_W-1:0]   rounds_q, rounds_d;
  logic [fcaa_pkg::CH_W-1:0]      div_ch_q, div_ch_d;
  logic [fcaa_pkg::BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic                           mode_q;
  logic [fcaa_pkg::SUM_W-1:0]     shift_q;
  logic [fcaa_pkg::SAMPLE_W-1:0]  level_q [fcaa_pkg::NUM_CH];
  logic                           out_valid_q;
  logic                           kind_q;
  logic [fcaa_pkg::SAMPLE_W-1:0]  out_level_q [fcaa_pkg::NUM_CH];
  logic [fcaa_pkg::TEMP_W-1:0]    temp_q;

  logic                           accept;
  logic                           load_out;
  logic                           level_we;
  logic                           div_start;
  logic                           div_done;
  logic [fcaa_pkg::SUM_W-1:0]     quotient;
  logic [fcaa_pkg::SUM_W-1:0]     sum;
  logic [fcaa_pkg::ROUND_W-1:0]   eff_count;
  logic [fcaa_pkg::ROUND_W-1:0]   rounds_inc;
  logic [fcaa_pkg::SAMPLE_W-1:0]  avg;
  logic [fcaa_pkg::TEMP_W-1:0]    temp_diff;
  logic [fcaa_pkg::TEMP_W-1:0]    temp_result;
  logic                           slot_free;
  fcaa_pkg::acc_ctrl_t            acc_ctrl;

  assign accept     = in_valid_i & ~in_stall_o;
  assign in_stall_o = state_q != fcaa_pkg::ST_IDLE;
  assign slot_free  = ~out_valid_q | ~out_stall_i;
  assign rounds_inc = rounds_q + 1'b1;

  always_comb begin
    if (sample_count_q == '0 ||
        sample_count_q > fcaa_pkg::COUNT_W'(fcaa_pkg::MAX_ROUNDS)) begin
      eff_count = fcaa_pkg::ROUND_W'(1);
    end else begin
      eff_count = sample_count_q[fcaa_pkg::ROUND_W-1:0];
    end
  end

  assign temp_diff = fcaa_pkg::TEMP_W'(shift_q[fcaa_pkg::SAMPLE_W-1:0])
                   - fcaa_pkg::TEMP_W'(temp_offset_q);
  assign temp_result = (temp_offset_q == '0)
                     ? fcaa_pkg::TEMP_W'(shift_q[fcaa_pkg::SAMPLE_W-1:0])
                     : {temp_diff[fcaa_pkg::TEMP_W-3:0], 2'b00} + fcaa_pkg::TEMP_BASE;

  assign avg = (quotient > fcaa_pkg::SUM_W'(fcaa_pkg::FULL_SCALE))
             ? fcaa_pkg::FULL_SCALE : quotient[fcaa_pkg::SAMPLE_W-1:0];

  always_comb begin
    state_d        = state_q;
    channel_pos_d  = channel_pos_q;
    rounds_d       = rounds_q;
    div_ch_d       = div_ch_q;
    bit_cnt_d      = bit_cnt_q;
    acc_ctrl.clear = 1'b0;
    acc_ctrl.shift = 1'b0;
    acc_ctrl.first = bit_cnt_q == '0;
    acc_ctrl.idx   = channel_pos_q;
    div_start      = 1'b0;
    level_we       = 1'b0;
    load_out       = 1'b0;
    case (state_q)
      fcaa_pkg::ST_IDLE: begin
        bit_cnt_d = '0;
        if (accept) begin
          state_d = mode_i ? fcaa_pkg::ST_EMIT : fcaa_pkg::ST_ACC;
        end
      end
      fcaa_pkg::ST_ACC: begin
        acc_ctrl.shift = 1'b1;
        bit_cnt_d      = bit_cnt_q + 1'b1;
        if (bit_cnt_q == fcaa_pkg::BIT_CNT_W'(fcaa_pkg::SUM_W - 1)) begin
          channel_pos_d = channel_pos_q + 1'b1;
          state_d       = fcaa_pkg::ST_IDLE;
          if (channel_pos_q == fcaa_pkg::CH_W'(fcaa_pkg::NUM_CH - 1)) begin
            rounds_d = rounds_inc;
            if (rounds_inc >= eff_count) begin
              div_ch_d = '0;
              state_d  = fcaa_pkg::ST_DIV_GO;
            end
          end
        end
      end
      fcaa_pkg::ST_DIV_GO: begin
        acc_ctrl.idx = div_ch_q;
        div_start    = 1'b1;
        state_d      = fcaa_pkg::ST_DIV_RUN;
      end
      fcaa_pkg::ST_DIV_RUN: begin
        acc_ctrl.idx = div_ch_q;
        if (div_done) begin
          level_we = 1'b1;
          div_ch_d = div_ch_q + 1'b1;
          if (div_ch_q == fcaa_pkg::CH_W'(fcaa_pkg::NUM_CH - 1)) begin
            state_d = fcaa_pkg::ST_EMIT;
          end else begin
            state_d = fcaa_pkg::ST_DIV_GO;
          end
        end
      end
      fcaa_pkg::ST_EMIT: begin
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = fcaa_pkg::ST_IDLE;
          if (mode_q == fcaa_pkg::KIND_VOLTAGE) begin
            acc_ctrl.clear = 1'b1;
            channel_pos_d  = '0;
            rounds_d       = '0;
          end
        end
      end
      default: begin
        state_d = fcaa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= fcaa_pkg::ST_IDLE;
      channel_pos_q  <= '0;
      rounds_q       <= '0;
      div_ch_q       <= '0;
      bit_cnt_q      <= '0;
      sample_count_q <= fcaa_pkg::COUNT_W'(1);
      temp_offset_q  <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      channel_pos_q <= channel_pos_d;
      rounds_q      <= rounds_d;
      div_ch_q      <= div_ch_d;
      bit_cnt_q     <= bit_cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fcaa_pkg::REG_SAMPLE_COUNT: sample_count_q <= cfg_data_i[fcaa_pkg::COUNT_W-1:0];
          fcaa_pkg::REG_TEMP_OFFSET:  temp_offset_q  <= cfg_data_i[fcaa_pkg::SAMPLE_W-1:0];
          default: begin
          end
        endcase
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      shift_q <= fcaa_pkg::SUM_W'(sample_i);
    end else if (acc_ctrl.shift) begin
      shift_q <= {1'b0, shift_q[fcaa_pkg::SUM_W-1:1]};
    end
    if (level_we) begin
      level_q[div_ch_q] <= fcaa_pkg::FULL_SCALE - avg;
    end
    if (load_out) begin
      kind_q <= mode_q;
      for (int i = 0; i < fcaa_pkg::NUM_CH; i++) begin
        out_level_q[i] <= (mode_q == fcaa_pkg::KIND_TEMP) ? '0 : level_q[i];
      end
      temp_q <= (mode_q == fcaa_pkg::KIND_TEMP) ? temp_result : '0;
    end
  end

  fcaa_acc u_acc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (acc_ctrl),
    .addend_bit_i (shift_q[0]),
    .sum_o        (sum)
  );

  fcaa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum),
    .divisor_i  (rounds_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign x1_level_o   = out_level_q[0];
  assign x2_level_o   = out_level_q[1];
  assign y1_level_o   = out_level_q[2];
  assign y2_level_o   = out_level_q[3];
  assign temp_value_o = temp_q;

endmodule

// ===== src/fcaa_acc.sv =====
// Four channel sums, each a shift register that takes a bit-serial add one bit per cycle.
// Depends on fcaa_pkg.
module fcaa_acc (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fcaa_pkg::acc_ctrl_t       ctrl_i,
  input  logic                      addend_bit_i,
  output logic [fcaa_pkg::SUM_W-1:0] sum_o
);

  logic [fcaa_pkg::SUM_W-1:0] sums_q [fcaa_pkg::NUM_CH];
  logic                       carry_q, carry_d;
  logic                       carry_in;
  logic                       sum_bit;
  logic [fcaa_pkg::SUM_W-1:0] cur;

  assign cur      = sums_q[ctrl_i.idx];
  assign carry_in = ctrl_i.first ? 1'b0 : carry_q;
  assign sum_bit  = cur[0] ^ addend_bit_i ^ carry_in;
  assign carry_d  = (cur[0] & addend_bit_i) | (cur[0] & carry_in) | (addend_bit_i & carry_in);
  assign sum_o    = cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fcaa_pkg::NUM_CH; i++) begin
        sums_q[i] <= '0;
      end
      carry_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < fcaa_pkg::NUM_CH; i++) begin
        sums_q[i] <= '0;
      end
      carry_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      sums_q[ctrl_i.idx] <= {sum_bit, cur[fcaa_pkg::SUM_W-1:1]};
      carry_q            <= carry_d;
    end
  end

endmodule

// ===== src/fcaa_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Depends on fcaa_pkg.
module fcaa_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fcaa_pkg::SUM_W-1:0]   dividend_i,
  input  logic [fcaa_pkg::ROUND_W-1:0] divisor_i,
  output logic                         done_o,
  output logic [fcaa_pkg::SUM_W-1:0]   quotient_o
);

  logic [fcaa_pkg::SUM_W-1:0]     dq_q;
  logic [fcaa_pkg::ROUND_W-1:0]   rem_q;
  logic [fcaa_pkg::BIT_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;
  logic [fcaa_pkg::ROUND_W:0]     trial;
  logic [fcaa_pkg::ROUND_W:0]     diff;
  logic                           ge;
  logic                           last;

  assign trial = {rem_q, dq_q[fcaa_pkg::SUM_W-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};
  assign last  = cnt_q == fcaa_pkg::BIT_CNT_W'(fcaa_pkg::SUM_W - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q & last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[fcaa_pkg::ROUND_W-1:0] : trial[fcaa_pkg::ROUND_W-1:0];
      dq_q  <= {dq_q[fcaa_pkg::SUM_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for four_channel_adc_averager: random bursts of converter samples,
// random output stalls and register changes between phases, checked against an in-line predictor.
// Depends on fcaa_pkg and the averager RTL.
module tb;

  localparam logic        MODE_VOLTAGE  = 1'b0;
  localparam logic        MODE_TEMP     = 1'b1;
  localparam int          TEMP_GAIN     = 4;
  localparam int          TEMP_BASE_DD  = 300;
  localparam int          RANDOM_ITEMS  = 2000;
  localparam int          SETTLE_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int          JUNK_W        = fcaa_pkg::CFG_DATA_W - fcaa_pkg::COUNT_W;

  typedef struct packed {
    logic                                                 kind;
    logic [fcaa_pkg::NUM_CH-1:0][fcaa_pkg::SAMPLE_W-1:0] level;
    logic [fcaa_pkg::TEMP_W-1:0]                          temp;
  } reading_t;

  class reading_scoreboard;
    logic [fcaa_pkg::COUNT_W-1:0]  rounds_cfg;
    logic [fcaa_pkg::SAMPLE_W-1:0] temp_offset;
    logic [fcaa_pkg::CH_W-1:0]     chan_pos;
    logic [fcaa_pkg::SUM_W-1:0]    chan_sum[fcaa_pkg::NUM_CH];
    logic [fcaa_pkg::ROUND_W-1:0]  rounds_seen;
    reading_t                      pending_readings[$];
    int unsigned                   failures;

    function new();
      rounds_cfg  = 8'd1;
      temp_offset = '0;
      failures    = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      chan_pos    = '0;
      rounds_seen = '0;
      foreach (chan_sum[k]) chan_sum[k] = '0;
    endfunction

    function void write_register(logic [fcaa_pkg::CFG_IDX_W-1:0] idx,
                                 logic [fcaa_pkg::CFG_DATA_W-1:0] data);
      if (idx == fcaa_pkg::REG_SAMPLE_COUNT) rounds_cfg = data[fcaa_pkg::COUNT_W-1:0];
      else if (idx == fcaa_pkg::REG_TEMP_OFFSET) temp_offset = data[fcaa_pkg::SAMPLE_W-1:0];
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction

    // Works out the reading that an accepted sample causes, if any.
    function void note_sample(logic mode, logic [fcaa_pkg::SAMPLE_W-1:0] sample);
      reading_t                     r;
      int                           calib;
      logic [fcaa_pkg::COUNT_W-1:0] eff;
      logic [fcaa_pkg::SUM_W-1:0]   avg;
      r = '0;
      if (mode == MODE_TEMP) begin
        if (temp_offset == 0) calib = int'(sample);
        else calib = (int'(sample) - int'(temp_offset)) * TEMP_GAIN + TEMP_BASE_DD;
        r.kind = fcaa_pkg::KIND_TEMP;
        r.temp = calib[fcaa_pkg::TEMP_W-1:0];
        pending_readings.push_back(r);
        return;
      end
      chan_sum[chan_pos] = chan_sum[chan_pos] + sample;
      if (chan_pos != fcaa_pkg::CH_W'(fcaa_pkg::NUM_CH - 1)) begin
        chan_pos = chan_pos + 1'b1;
        return;
      end
      chan_pos    = '0;
      rounds_seen = rounds_seen + 1'b1;
      eff = (rounds_cfg == 0 || rounds_cfg > fcaa_pkg::MAX_ROUNDS)
          ? fcaa_pkg::COUNT_W'(1) : rounds_cfg;
      if (rounds_seen < eff) return;
      r.kind = fcaa_pkg::KIND_VOLTAGE;
      for (int k = 0; k < fcaa_pkg::NUM_CH; k++) begin
        avg = chan_sum[k] / rounds_seen;
        if (avg > fcaa_pkg::FULL_SCALE) avg = fcaa_pkg::SUM_W'(fcaa_pkg::FULL_SCALE);
        r.level[k] = fcaa_pkg::FULL_SCALE - avg[fcaa_pkg::SAMPLE_W-1:0];
      end
      pending_readings.push_back(r);
      clear_sums();
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (pending_readings.size() == 0) begin
        if (failures < 10)
          $display("%0t: unexpected reading kind %0d x1 %0d x2 %0d y1 %0d y2 %0d temp %0d",
                   $realtime, got.kind, got.level[0], got.level[1], got.level[2],
                   got.level[3], $signed(got.temp));
        failures++;
        return;
      end
      want = pending_readings.pop_front();
      if (got.kind !== want.kind || got.level !== want.level || got.temp !== want.temp) begin
        if (failures < 10) begin
          $display("%0t: mismatch, expected kind %0d x1 %0d x2 %0d y1 %0d y2 %0d temp %0d",
                   $realtime, want.kind, want.level[0], want.level[1], want.level[2],
                   want.level[3], $signed(want.temp));
          $display("%0t:           got      kind %0d x1 %0d x2 %0d y1 %0d y2 %0d temp %0d",
                   $realtime, got.kind, got.level[0], got.level[1], got.level[2],
                   got.level[3], $signed(got.temp));
        end
        failures++;
      end
    endfunction

    function int unsigned final_failures();
      return failures + pending_readings.size();
    endfunction
  endclass

  logic                                 clk_i        = 1'b0;
  logic                                 rst_ni       = 1'b0;
  logic                                 in_valid_i   = 1'b0;
  logic                                 in_stall_o;
  logic                                 mode_i       = MODE_VOLTAGE;
  logic [fcaa_pkg::SAMPLE_W-1:0]        sample_i     = '0;
  logic                                 out_valid_o;
  logic                                 out_stall_i  = 1'b0;
  logic                                 kind_o;
  logic [fcaa_pkg::SAMPLE_W-1:0]        x1_level_o;
  logic [fcaa_pkg::SAMPLE_W-1:0]        x2_level_o;
  logic [fcaa_pkg::SAMPLE_W-1:0]        y1_level_o;
  logic [fcaa_pkg::SAMPLE_W-1:0]        y2_level_o;
  logic signed [fcaa_pkg::TEMP_W-1:0]   temp_value_o;
  logic                                 cfg_we_i     = 1'b0;
  logic [fcaa_pkg::CFG_IDX_W-1:0]       cfg_idx_i    = fcaa_pkg::REG_SAMPLE_COUNT;
  logic [fcaa_pkg::CFG_DATA_W-1:0]      cfg_data_i   = '0;

  reading_scoreboard sb;
  int unsigned       cycles      = 0;
  int unsigned       stall_left  = 0;
  int unsigned       stall_style = 0;

  four_channel_adc_averager uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .x1_level_o  (x1_level_o),
    .x2_level_o  (x2_level_o),
    .y1_level_o  (y1_level_o),
    .y2_level_o  (y2_level_o),
    .temp_value_o(temp_value_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver checks each accepted reading and stalls in segments of varying character.
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && !out_stall_i)
      sb.check_reading({kind_o, y2_level_o, y1_level_o, x2_level_o, x1_level_o, temp_value_o});
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(10, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= stall_left[4];
    endcase
  end

  task automatic send_item(logic mode, logic [fcaa_pkg::SAMPLE_W-1:0] sample);
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    sample_i   <= sample;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(mode, sample);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The two bits above the count carry junk, which the block must ignore.
  task automatic write_config(logic [fcaa_pkg::COUNT_W-1:0] count,
                              logic [fcaa_pkg::SAMPLE_W-1:0] offset);
    logic [JUNK_W-1:0] junk;
    junk = JUNK_W'($urandom_range(0, 3));
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= fcaa_pkg::REG_SAMPLE_COUNT;
    cfg_data_i <= {junk, count};
    @(posedge clk_i);
    sb.write_register(fcaa_pkg::REG_SAMPLE_COUNT, {junk, count});
    cfg_idx_i  <= fcaa_pkg::REG_TEMP_OFFSET;
    cfg_data_i <= offset;
    @(posedge clk_i);
    sb.write_register(fcaa_pkg::REG_TEMP_OFFSET, offset);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned                   sent;
    int unsigned                   phase_len;
    int unsigned                   burst;
    int unsigned                   gap;
    bit                            bursty;
    logic [fcaa_pkg::COUNT_W-1:0]  count;
    logic [fcaa_pkg::SAMPLE_W-1:0] offset;
    logic                          mode;
    logic [fcaa_pkg::SAMPLE_W-1:0] sample;

    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: one round per reading and raw temperature.
    send_item(MODE_TEMP, 10'd0);
    send_item(MODE_TEMP, 10'd1023);
    send_item(MODE_VOLTAGE, 10'd0);
    send_item(MODE_VOLTAGE, 10'd1023);
    send_item(MODE_VOLTAGE, 10'h2AA);
    send_item(MODE_VOLTAGE, 10'h155);
    settle();

    // Two rounds, full offset, and a temperature sample in the middle of accumulation.
    write_config(8'd2, 10'd1023);
    send_item(MODE_TEMP, 10'd0);
    send_item(MODE_TEMP, 10'd1023);
    send_item(MODE_VOLTAGE, 10'd1023);
    send_item(MODE_VOLTAGE, 10'd1023);
    send_item(MODE_VOLTAGE, 10'd0);
    send_item(MODE_VOLTAGE, 10'd0);
    send_item(MODE_TEMP, 10'd512);
    send_item(MODE_VOLTAGE, 10'd1023);
    send_item(MODE_VOLTAGE, 10'd0);
    send_item(MODE_VOLTAGE, 10'd1023);
    send_item(MODE_VOLTAGE, 10'd0);
    settle();

    // The count drops after one round, so the next round completes a reading of two.
    write_config(8'd3, 10'd1);
    send_item(MODE_TEMP, 10'd1023);
    send_item(MODE_VOLTAGE, 10'd1023);
    send_item(MODE_VOLTAGE, 10'd1000);
    send_item(MODE_VOLTAGE, 10'd1);
    send_item(MODE_VOLTAGE, 10'd0);
    settle();
    write_config(8'd0, 10'd1);
    send_item(MODE_VOLTAGE, 10'd1022);
    send_item(MODE_VOLTAGE, 10'd7);
    send_item(MODE_VOLTAGE, 10'd0);
    send_item(MODE_VOLTAGE, 10'd1023);
    settle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: count = 8'd0;
        1: count = 8'd1;
        2: count = 8'd8;
        3: count = fcaa_pkg::COUNT_W'($urandom_range(9, 255));
        default: count = fcaa_pkg::COUNT_W'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 3))
        0: offset = 10'd0;
        1: offset = 10'd1;
        2: offset = 10'd1023;
        default: offset = fcaa_pkg::SAMPLE_W'($urandom_range(0, 1023));
      endcase
      write_config(count, offset);
      phase_len = $urandom_range(40, 250);
      bursty    = ($urandom_range(0, 3) != 0);
      while (phase_len > 0) begin
        burst = $urandom_range(1, 24);
        while (burst > 0 && phase_len > 0) begin
          mode = ($urandom_range(0, 5) == 0) ? MODE_TEMP : MODE_VOLTAGE;
          case ($urandom_range(0, 7))
            0: sample = 10'd0;
            1: sample = 10'd1023;
            default: sample = fcaa_pkg::SAMPLE_W'($urandom_range(0, 1023));
          endcase
          send_item(mode, sample);
          burst--;
          phase_len--;
          sent++;
        end
        gap = bursty ? $urandom_range(0, 12) : 0;
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      settle();
    end

    if (sb.final_failures() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
